### rtl/scfp_pkg.sv
// Shared types and constants for the serial command frame parser.
// Depends on nothing; used by every module in rtl/.
package scfp_pkg;

    // Framing bytes
    localparam logic [7:0] HDR_BYTE    = 8'hFF;
    localparam logic [7:0] ID_BYTE     = 8'h02;
    localparam logic [7:0] LEN_BYTE    = 8'h06;

    localparam int unsigned PAYLOAD_LEN = 16;

    // Frame position codes
    typedef logic [4:0] pos_t;
    localparam pos_t POS_HUNT0      = 5'd0;
    localparam pos_t POS_HUNT1      = 5'd1;
    localparam pos_t POS_WAIT_ID    = 5'd2;
    localparam pos_t POS_WAIT_LEN   = 5'd3;
    localparam pos_t POS_DATA_FIRST = 5'd4;
    localparam pos_t POS_DATA_LAST  = 5'd19;

    // One decoded command
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic        [7:0]  dir_x;
        logic signed [15:0] pos_y;
        logic        [7:0]  dir_y;
        logic signed [15:0] angle;
        logic signed [15:0] goal_x;
        logic        [7:0]  goal_dir_x;
        logic signed [15:0] goal_y;
        logic        [7:0]  goal_dir_y;
        logic signed [15:0] grip_angle;
    } cmd_t;

endpackage

### rtl/scfp_framer.sv
// Frame position tracking, payload capture and command decode.
// Depends on scfp_pkg.
module scfp_framer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             take,
    input  logic [7:0]       rx_byte,
    output logic             cmd_done,
    output scfp_pkg::cmd_t   cmd
);

    localparam int unsigned HELD = scfp_pkg::PAYLOAD_LEN - 1;

    scfp_pkg::pos_t pos_reg;
    scfp_pkg::pos_t pos_next;
    scfp_pkg::pos_t pos_eff;
    logic [7:0]     data_reg [HELD];
    logic [7:0]     p [scfp_pkg::PAYLOAD_LEN];
    logic           shift_en;

    // Treat unused position codes as the start of the hunt
    assign pos_eff = (pos_reg > scfp_pkg::POS_DATA_LAST) ? scfp_pkg::POS_HUNT0 : pos_reg;

    // Advance the frame position on each transfer
    always_comb begin
        pos_next = pos_reg;
        cmd_done = 1'b0;
        shift_en = 1'b0;
        if (take) begin
            case (pos_eff)
                scfp_pkg::POS_HUNT0, scfp_pkg::POS_HUNT1: begin
                    pos_next = (rx_byte == scfp_pkg::HDR_BYTE) ? pos_eff + 5'd1
                                                               : scfp_pkg::POS_HUNT0;
                end
                scfp_pkg::POS_WAIT_ID: begin
                    if (rx_byte == scfp_pkg::ID_BYTE) pos_next = scfp_pkg::POS_WAIT_LEN;
                    else pos_next = scfp_pkg::POS_WAIT_ID;
                end
                scfp_pkg::POS_WAIT_LEN: begin
                    if (rx_byte == scfp_pkg::LEN_BYTE) pos_next = scfp_pkg::POS_DATA_FIRST;
                    else pos_next = scfp_pkg::POS_WAIT_LEN;
                end
                scfp_pkg::POS_DATA_LAST: begin
                    pos_next = scfp_pkg::POS_HUNT0;
                    cmd_done = 1'b1;
                end
                default: begin
                    // payload bytes before the last one
                    pos_next = pos_eff + 5'd1;
                    shift_en = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= scfp_pkg::POS_HUNT0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // Shift payload bytes in; the oldest ends up at index 0
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            for (int i = 0; i < HELD - 1; i++) begin
                data_reg[i] <= data_reg[i+1];
            end
            data_reg[HELD-1] <= rx_byte;
        end
    end

    // Last payload byte comes straight from the input
    always_comb begin
        for (int i = 0; i < HELD; i++) begin
            p[i] = data_reg[i];
        end
        p[HELD] = rx_byte;
    end

    // Decode the little-endian fields
    always_comb begin
        cmd.pos_x      = $signed({p[1], p[0]});
        cmd.dir_x      = p[2];
        cmd.pos_y      = $signed({p[4], p[3]});
        cmd.dir_y      = p[5];
        cmd.angle      = $signed({p[7], p[6]});
        cmd.goal_x     = $signed({p[9], p[8]});
        cmd.goal_dir_x = p[10];
        cmd.goal_y     = $signed({p[12], p[11]});
        cmd.goal_dir_y = p[13];
        cmd.grip_angle = $signed({p[15], p[14]});
    end

endmodule

### rtl/scfp_out_reg.sv
// Result register: holds a decoded command until the downstream transfer.
// Depends on scfp_pkg.
module scfp_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  scfp_pkg::cmd_t   cmd_in,
    input  logic             out_ready,
    output logic             out_valid,
    output scfp_pkg::cmd_t   cmd_out
);

    logic           valid_reg;
    logic           valid_next;
    scfp_pkg::cmd_t cmd_reg;

    // Drop valid on transfer, set it on a new load
    always_comb begin
        valid_next = valid_reg;
        if (out_ready) valid_next = 1'b0;
        if (load) valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload until replaced
    always_ff @(posedge aclk) begin
        if (load) begin
            cmd_reg <= cmd_in;
        end
    end

    assign out_valid = valid_reg;
    assign cmd_out   = cmd_reg;

endmodule

### rtl/serial_command_frame_parser_unit.sv
// Serial command frame parser: one received byte per transfer, one command per frame.
// Latency: the command appears on m_ the cycle after its last payload byte is taken.
// Throughput: one byte per cycle; s_ready drops only while a result is held and
// m_ready is low, since the single result register is the only buffer.
// Reset (aresetn low, synchronous): return to the header hunt, drop m_valid;
// captured payload bytes are not cleared. Depends on scfp_pkg, scfp_framer, scfp_out_reg.
module serial_command_frame_parser_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_pos_x,
    output logic [7:0]         m_dir_x,
    output logic signed [15:0] m_pos_y,
    output logic [7:0]         m_dir_y,
    output logic signed [15:0] m_angle,
    output logic signed [15:0] m_goal_x,
    output logic [7:0]         m_goal_dir_x,
    output logic signed [15:0] m_goal_y,
    output logic [7:0]         m_goal_dir_y,
    output logic signed [15:0] m_grip_angle
);

    logic           take;
    logic           cmd_done;
    scfp_pkg::cmd_t cmd;
    scfp_pkg::cmd_t cmd_out;

    // Accept while the result register is empty or draining
    assign s_ready = !m_valid || m_ready;
    assign take    = s_valid && s_ready;

    scfp_framer u_framer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .rx_byte  (s_rx_byte),
        .cmd_done (cmd_done),
        .cmd      (cmd)
    );

    scfp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (cmd_done),
        .cmd_in    (cmd),
        .out_ready (m_ready),
        .out_valid (m_valid),
        .cmd_out   (cmd_out)
    );

    assign m_pos_x      = cmd_out.pos_x;
    assign m_dir_x      = cmd_out.dir_x;
    assign m_pos_y      = cmd_out.pos_y;
    assign m_dir_y      = cmd_out.dir_y;
    assign m_angle      = cmd_out.angle;
    assign m_goal_x     = cmd_out.goal_x;
    assign m_goal_dir_x = cmd_out.goal_dir_x;
    assign m_goal_y     = cmd_out.goal_y;
    assign m_goal_dir_y = cmd_out.goal_dir_y;
    assign m_grip_angle = cmd_out.grip_angle;

endmodule

### test/tb_serial_command_frame_parser_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for serial_command_frame_parser_unit: byte stream in, commands out.
// Depends on scfp_pkg and the RTL under rtl/; uses its own frame tracker to predict commands.
module tb_serial_command_frame_parser_unit;

    // One row of the directed byte table; a typed row carries its command spelled out
    typedef struct packed {
        logic [7:0]     rx;
        logic           typed;
        scfp_pkg::cmd_t want;
    } stim_row_t;

    localparam scfp_pkg::cmd_t NO_CMD = '0;
    // Payload chosen for field extremes and marker values carried as data
    localparam scfp_pkg::cmd_t EXTREME_CMD = '{16'h8000, 8'hFF, 16'h7FFF, 8'h00, 16'hFFFF,
                                               16'h0602, 8'h02, 16'h0000, 8'h06, 16'h0001};
    localparam int DIRECTED_ROWS = 24;
    localparam int MAX_REPORTS   = 10;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_rx_byte;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_pos_x;
    logic [7:0]         m_dir_x;
    logic signed [15:0] m_pos_y;
    logic [7:0]         m_dir_y;
    logic signed [15:0] m_angle;
    logic signed [15:0] m_goal_x;
    logic [7:0]         m_goal_dir_x;
    logic signed [15:0] m_goal_y;
    logic [7:0]         m_goal_dir_y;
    logic signed [15:0] m_grip_angle;

    // Frame tracker state and commands still owed by the block
    scfp_pkg::pos_t frame_pos;
    logic [7:0]     payload_mem [scfp_pkg::PAYLOAD_LEN];
    scfp_pkg::cmd_t pending_cmds [$];

    int fault_count        = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_requests      = 0;
    int holds_served       = 0;
    int bytes_counted      = 0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{scfp_pkg::HDR_BYTE, 1'b0, NO_CMD},  // one header byte, then a break restarts the hunt
        '{8'h00,              1'b0, NO_CMD},
        '{scfp_pkg::HDR_BYTE, 1'b0, NO_CMD},
        '{scfp_pkg::HDR_BYTE, 1'b0, NO_CMD},
        '{8'h05,              1'b0, NO_CMD},  // stray byte while waiting for the id
        '{scfp_pkg::ID_BYTE,  1'b0, NO_CMD},
        '{scfp_pkg::HDR_BYTE, 1'b0, NO_CMD},  // stray byte while waiting for the length
        '{scfp_pkg::LEN_BYTE, 1'b0, NO_CMD},
        '{8'h00,              1'b0, NO_CMD},  // payload starts here
        '{8'h80,              1'b0, NO_CMD},
        '{8'hFF,              1'b0, NO_CMD},
        '{8'hFF,              1'b0, NO_CMD},
        '{8'h7F,              1'b0, NO_CMD},
        '{8'h00,              1'b0, NO_CMD},
        '{8'hFF,              1'b0, NO_CMD},
        '{8'hFF,              1'b0, NO_CMD},
        '{8'h02,              1'b0, NO_CMD},  // marker values captured as plain data
        '{8'h06,              1'b0, NO_CMD},
        '{8'h02,              1'b0, NO_CMD},
        '{8'h00,              1'b0, NO_CMD},
        '{8'h00,              1'b0, NO_CMD},
        '{8'h06,              1'b0, NO_CMD},
        '{8'h01,              1'b0, NO_CMD},
        '{8'h00,              1'b1, EXTREME_CMD}
    };

    serial_command_frame_parser_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pos_x      (m_pos_x),
        .m_dir_x      (m_dir_x),
        .m_pos_y      (m_pos_y),
        .m_dir_y      (m_dir_y),
        .m_angle      (m_angle),
        .m_goal_x     (m_goal_x),
        .m_goal_dir_x (m_goal_dir_x),
        .m_goal_y     (m_goal_y),
        .m_goal_dir_y (m_goal_dir_y),
        .m_grip_angle (m_grip_angle)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Advance the frame tracker by one byte; return 1 when it completes a command
    function automatic bit parse_byte(input logic [7:0] rx, output scfp_pkg::cmd_t cmd,
                                      output bit ignored);
        scfp_pkg::pos_t here;
        bit             done;
        here    = (frame_pos > scfp_pkg::POS_DATA_LAST) ? scfp_pkg::POS_HUNT0 : frame_pos;
        cmd     = '0;
        ignored = 1'b0;
        done    = 1'b0;
        if (here <= scfp_pkg::POS_HUNT1) begin
            frame_pos = (rx == scfp_pkg::HDR_BYTE) ? scfp_pkg::pos_t'(here + 1)
                                                   : scfp_pkg::POS_HUNT0;
            ignored   = (here == scfp_pkg::POS_HUNT0) && (rx != scfp_pkg::HDR_BYTE);
        end else if (here == scfp_pkg::POS_WAIT_ID) begin
            if (rx == scfp_pkg::ID_BYTE) frame_pos = scfp_pkg::POS_WAIT_LEN;
            else ignored = 1'b1;
        end else if (here == scfp_pkg::POS_WAIT_LEN) begin
            if (rx == scfp_pkg::LEN_BYTE) frame_pos = scfp_pkg::POS_DATA_FIRST;
            else ignored = 1'b1;
        end else begin
            payload_mem[4'(here - scfp_pkg::POS_DATA_FIRST)] = rx;
            if (here == scfp_pkg::POS_DATA_LAST) begin
                // Unpack little-endian words and single direction bytes
                cmd.pos_x      = {payload_mem[1], payload_mem[0]};
                cmd.dir_x      = payload_mem[2];
                cmd.pos_y      = {payload_mem[4], payload_mem[3]};
                cmd.dir_y      = payload_mem[5];
                cmd.angle      = {payload_mem[7], payload_mem[6]};
                cmd.goal_x     = {payload_mem[9], payload_mem[8]};
                cmd.goal_dir_x = payload_mem[10];
                cmd.goal_y     = {payload_mem[12], payload_mem[11]};
                cmd.goal_dir_y = payload_mem[13];
                cmd.grip_angle = {payload_mem[15], payload_mem[14]};
                frame_pos      = scfp_pkg::POS_HUNT0;
                done           = 1'b1;
            end else begin
                frame_pos = scfp_pkg::pos_t'(here + 1);
            end
        end
        return done;
    endfunction

    // Payload content: mostly uniform, a quarter from edge and marker values
    function automatic logic [7:0] data_byte();
        logic [7:0] picks [8] = '{8'h00, 8'hFF, 8'h80, 8'h7F, scfp_pkg::ID_BYTE,
                                  scfp_pkg::LEN_BYTE, 8'h01, 8'hFE};
        if ($urandom_range(0, 3) == 0) return picks[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Line noise, biased toward framing bytes
    function automatic logic [7:0] noise_byte();
        logic [7:0] picks [3] = '{scfp_pkg::HDR_BYTE, scfp_pkg::ID_BYTE, scfp_pkg::LEN_BYTE};
        if ($urandom_range(0, 2) == 0) return picks[$urandom_range(0, 2)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
            note_fault($sformatf("%s expected %h, got %h", field, want, got));
    endtask

    // Offer one byte, hold it until the transfer, then record what it should produce
    task automatic send_byte(input logic [7:0] rx, input logic typed,
                             input scfp_pkg::cmd_t want);
        scfp_pkg::cmd_t predicted;
        bit             produced;
        bit             ignored;
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        do @(posedge aclk); while (s_ready !== 1'b1);
        produced = parse_byte(rx, predicted, ignored);
        if (produced) pending_cmds.push_back(typed ? want : predicted);
        if (!ignored) bytes_counted++;
    endtask

    task automatic push_byte(input logic [7:0] rx);
        send_byte(rx, 1'b0, NO_CMD);
    endtask

    task automatic push_header();
        push_byte(scfp_pkg::HDR_BYTE);
        push_byte(scfp_pkg::HDR_BYTE);
        push_byte(scfp_pkg::ID_BYTE);
        push_byte(scfp_pkg::LEN_BYTE);
    endtask

    // Stop offering and wait for every owed command
    task automatic drain_commands();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
    endtask

    // Mostly clean frames, with noise, broken headers and cut-short frames mixed in
    task automatic run_random_phase(input int send_pct, input int recv_pct, input int quota);
        int goal;
        int kind;
        sender_idle_pct    = send_pct;
        receiver_stall_pct = recv_pct;
        goal               = bytes_counted + quota;
        while (bytes_counted < goal) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                push_header();
                repeat (scfp_pkg::PAYLOAD_LEN) push_byte(data_byte());
            end else if (kind == 7) begin
                repeat ($urandom_range(1, 6)) push_byte(noise_byte());
            end else if (kind == 8) begin
                push_byte(scfp_pkg::HDR_BYTE);
                push_byte(8'($urandom_range(0, 254)));
            end else begin
                push_header();
                repeat ($urandom_range(1, scfp_pkg::PAYLOAD_LEN - 1)) push_byte(data_byte());
            end
        end
        drain_commands();
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_served) begin
                holds_served++;
                for (int left = 150; left > 0; left--) begin
                    m_ready <= 1'b0;
                    @(negedge aclk);
                end
            end
            m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Compare each command transfer with the oldest owed command
    always @(posedge aclk) begin
        scfp_pkg::cmd_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_cmds.size() == 0) begin
                note_fault("command transfer with none pending");
            end else begin
                want = pending_cmds.pop_front();
                check_field("pos_x", want.pos_x, m_pos_x);
                check_field("dir_x", want.dir_x, m_dir_x);
                check_field("pos_y", want.pos_y, m_pos_y);
                check_field("dir_y", want.dir_y, m_dir_y);
                check_field("angle", want.angle, m_angle);
                check_field("goal_x", want.goal_x, m_goal_x);
                check_field("goal_dir_x", want.goal_dir_x, m_goal_dir_x);
                check_field("goal_y", want.goal_y, m_goal_y);
                check_field("goal_dir_y", want.goal_dir_y, m_goal_dir_y);
                check_field("grip_angle", want.grip_angle, m_grip_angle);
            end
        end
    end

    // Main sequence
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = '0;
        frame_pos = scfp_pkg::POS_HUNT0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
        drain_commands();

        run_random_phase(24, 72, 400);
        run_random_phase(72, 24, 400);
        // Long receiver hold-off while bytes keep coming, so the block backs up
        hold_requests++;
        run_random_phase(0, 0, 400);

        repeat (8) @(posedge aclk);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
